/* rtl/dosp_pkg.sv */
package dosp_pkg;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_OPTHDR = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    // Result kinds carried on tuser
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_HDR_DONE = 2'd1;
    localparam logic [1:0] EV_OPT_START = 2'd2;
    localparam logic [1:0] EV_OPT_DATA = 2'd3;

    // End status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SHORT_HDR   = 2'd1;
    localparam logic [1:0] ST_SHORT_OPTHDR = 2'd2;
    localparam logic [1:0] ST_SHORT_DATA  = 2'd3;

    localparam logic [1:0] FIELD_LAST_BYTE = 2'd3;

    // Result tdata layout
    localparam int unsigned OUT_TDATA_W = 96;
    localparam int unsigned MT_LSB  = 0;
    localparam int unsigned TID_LSB = 8;
    localparam int unsigned OT_LSB  = 32;
    localparam int unsigned OL_LSB  = 48;
    localparam int unsigned DB_LSB  = 64;
    localparam int unsigned DI_LSB  = 72;
    localparam int unsigned OLAST_BIT = 88;
    localparam int unsigned ST_LSB  = 89;

endpackage

/* rtl/dhcpv6_option_stream_parser.sv */
// A request accepted at one edge shows its result on m_* right after that edge, from the result register.
// Throughput: one byte per cycle; s_tready stays high while the result register is empty
// or being taken, so a byte can enter every cycle under a draining sink.
// Reset: aresetn is synchronous, active low; it clears the parse state to the header
// phase and empties the result register.
module dhcpv6_option_stream_parser
    import dosp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_byte
    input  logic                   s_tlast,   // message_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] msg_type, [31:8] transaction_id, [47:32] option_type, [63:48] option_length,
    // [71:64] data_byte, [87:72] data_index, [88] option_last, [90:89] end_status,
    // [95:91] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]             m_tuser,   // [1:0] event_res
    output logic                   m_tlast    // message_end
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbc_reg, fbc_next;
    logic [7:0]  mt_reg, mt_next;
    logic [23:0] tid_reg, tid_next;
    logic [15:0] ot_reg, ot_next;
    logic [15:0] ol_reg, ol_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] pos_reg, pos_next;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0]             m_user_reg, m_user_next;
    logic                   m_last_reg;

    logic        accept;
    logic [7:0]  b;
    logic [1:0]  ev;
    logic [7:0]  o_mt;
    logic [23:0] o_tid;
    logic [15:0] o_ot, o_ol, o_di;
    logic [7:0]  o_db;
    logic        o_olast;
    logic [1:0]  st;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    always_comb begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        mt_next    = mt_reg;
        tid_next   = tid_reg;
        ot_next    = ot_reg;
        ol_next    = ol_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        ev      = EV_NONE;
        o_mt    = '0;
        o_tid   = '0;
        o_ot    = '0;
        o_ol    = '0;
        o_db    = '0;
        o_di    = '0;
        o_olast = 1'b0;
        st      = ST_OK;

        case (phase_reg)
            PH_OPTHDR: begin
                case (fbc_reg)
                    2'd0:    ot_next = {b, 8'h00};
                    2'd1:    ot_next = {ot_reg[15:8], b};
                    2'd2:    ol_next = {b, 8'h00};
                    default: ol_next = {ol_reg[15:8], b};
                endcase
                o_mt  = mt_reg;
                o_tid = tid_reg;
                if (fbc_reg == FIELD_LAST_BYTE) begin
                    fbc_next = '0;
                    ev       = EV_OPT_START;
                    o_ot     = ot_next;
                    o_ol     = ol_next;
                    if (ol_next == 16'd0) begin
                        o_olast = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                        left_next  = ol_next;
                        pos_next   = '0;
                    end
                end else begin
                    fbc_next = fbc_reg + 2'd1;
                end
            end
            PH_DATA: begin
                ev    = EV_OPT_DATA;
                o_mt  = mt_reg;
                o_tid = tid_reg;
                o_ot  = ot_reg;
                o_ol  = ol_reg;
                o_db  = b;
                o_di  = pos_reg;
                if (left_reg <= 16'd1) begin
                    o_olast    = 1'b1;
                    left_next  = '0;
                    pos_next   = '0;
                    phase_next = PH_OPTHDR;
                    fbc_next   = '0;
                end else begin
                    left_next = left_reg - 16'd1;
                    pos_next  = pos_reg + 16'd1;
                end
            end
            default: begin
                // header phase: type byte, then the transaction id MSB first
                if (fbc_reg == 2'd0) begin
                    mt_next  = b;
                    tid_next = '0;
                end else begin
                    tid_next = {tid_reg[15:0], b};
                end
                if (fbc_reg == FIELD_LAST_BYTE) begin
                    fbc_next   = '0;
                    phase_next = PH_OPTHDR;
                    ev         = EV_HDR_DONE;
                    o_mt       = mt_next;
                    o_tid      = tid_next;
                end else begin
                    fbc_next = fbc_reg + 2'd1;
                end
            end
        endcase

        // judge the message on the state it would leave, then restart
        if (s_tlast) begin
            case (phase_next)
                PH_OPTHDR: st = (fbc_next != 2'd0) ? ST_SHORT_OPTHDR : ST_OK;
                PH_DATA:   st = ST_SHORT_DATA;
                default:   st = ST_SHORT_HDR;
            endcase
            phase_next = PH_HEADER;
            fbc_next   = '0;
            mt_next    = '0;
            tid_next   = '0;
            ot_next    = '0;
            ol_next    = '0;
            left_next  = '0;
            pos_next   = '0;
        end

        m_data_next = '0;
        m_data_next[MT_LSB +: 8]   = o_mt;
        m_data_next[TID_LSB +: 24] = o_tid;
        m_data_next[OT_LSB +: 16]  = o_ot;
        m_data_next[OL_LSB +: 16]  = o_ol;
        m_data_next[DB_LSB +: 8]   = o_db;
        m_data_next[DI_LSB +: 16]  = o_di;
        m_data_next[OLAST_BIT]     = o_olast;
        m_data_next[ST_LSB +: 2]   = st;
        m_user_next = ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            fbc_reg     <= '0;
            mt_reg      <= '0;
            tid_reg     <= '0;
            ot_reg      <= '0;
            ol_reg      <= '0;
            left_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                fbc_reg     <= fbc_next;
                mt_reg      <= mt_next;
                tid_reg     <= tid_next;
                ot_reg      <= ot_next;
                ol_reg      <= ol_next;
                left_reg    <= left_next;
                pos_reg     <= pos_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/dosp_checker.sv */
module dosp_checker
    import dosp_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]             m_tuser,
    input logic                   m_tlast
);

    // a stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // every accepted request yields a result on the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // status only travels with the message end
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[ST_LSB +: 2] == ST_OK)
        else $error("end status without message end");

    // the request after a message end starts a fresh header
    a_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast ##1 (s_tvalid && s_tready)[->1]
            |=> m_tuser == EV_NONE && m_tdata[MT_LSB +: 8] == 8'd0)
        else $error("header state not cleared at message end");

    // empty results carry no option-last mark
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_NONE |-> !m_tdata[OLAST_BIT])
        else $error("option last on an empty result");

endmodule

bind dhcpv6_option_stream_parser dosp_checker u_dosp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* sim/dhcpv6_option_stream_parser_test.sv */
module dhcpv6_option_stream_parser_test
    import dosp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 650;
    localparam int unsigned MAX_GAP      = 12;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [1:0]  ev;
        logic [7:0]  mt;
        logic [23:0] tid;
        logic [15:0] ot;
        logic [15:0] ol;
        logic [7:0]  db;
        logic [15:0] di;
        logic        olast;
        logic        mend;
        logic [1:0]  st;
    } parse_result_t;

    class option_parse_tracker;
        phase_t          phase;
        logic [1:0]      field_cnt;
        logic [7:0]      msg_type;
        logic [23:0]     xid;
        logic [15:0]     opt_type;
        logic [15:0]     opt_len;
        logic [15:0]     bytes_left;
        logic [15:0]     position;
        parse_result_t   owed_results[$];
        int unsigned     errors;
        int unsigned     n_bytes;
        int unsigned     status_count[4];
        int unsigned     event_count[4];
        int unsigned     empty_opts;

        function new();
            errors     = 0;
            n_bytes    = 0;
            empty_opts = 0;
            foreach (status_count[i]) status_count[i] = 0;
            foreach (event_count[i]) event_count[i] = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = PH_HEADER;
            field_cnt  = 2'd0;
            msg_type   = 8'h00;
            xid        = 24'h000000;
            opt_type   = 16'h0000;
            opt_len    = 16'h0000;
            bytes_left = 16'h0000;
            position   = 16'h0000;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Work out the result that one accepted request owes.
        function void take_byte(logic [7:0] b, logic last);
            parse_result_t r;
            r = '0;
            n_bytes++;
            case (phase)
                PH_OPTHDR: begin
                    case (field_cnt)
                        2'd0:    opt_type = {b, 8'h00};
                        2'd1:    opt_type = opt_type | {8'h00, b};
                        2'd2:    opt_len  = {b, 8'h00};
                        default: opt_len  = opt_len | {8'h00, b};
                    endcase
                    r.mt  = msg_type;
                    r.tid = xid;
                    if (field_cnt == FIELD_LAST_BYTE) begin
                        field_cnt = 2'd0;
                        r.ev = EV_OPT_START;
                        r.ot = opt_type;
                        r.ol = opt_len;
                        if (opt_len == 16'h0000) begin
                            r.olast = 1'b1;
                            empty_opts++;
                        end else begin
                            phase      = PH_DATA;
                            bytes_left = opt_len;
                            position   = 16'h0000;
                        end
                    end else begin
                        field_cnt = field_cnt + 2'd1;
                    end
                end
                PH_DATA: begin
                    r.ev  = EV_OPT_DATA;
                    r.mt  = msg_type;
                    r.tid = xid;
                    r.ot  = opt_type;
                    r.ol  = opt_len;
                    r.db  = b;
                    r.di  = position;
                    if (bytes_left <= 16'd1) begin
                        r.olast    = 1'b1;
                        bytes_left = 16'h0000;
                        position   = 16'h0000;
                        phase      = PH_OPTHDR;
                        field_cnt  = 2'd0;
                    end else begin
                        bytes_left = bytes_left - 16'd1;
                        position   = position + 16'd1;
                    end
                end
                default: begin
                    if (field_cnt == 2'd0) begin
                        msg_type = b;
                        xid      = 24'h000000;
                    end else begin
                        xid = {xid[15:0], b};
                    end
                    if (field_cnt == FIELD_LAST_BYTE) begin
                        field_cnt = 2'd0;
                        phase     = PH_OPTHDR;
                        r.ev      = EV_HDR_DONE;
                        r.mt      = msg_type;
                        r.tid     = xid;
                    end else begin
                        field_cnt = field_cnt + 2'd1;
                    end
                end
            endcase

            // Judge the message once its final byte has been taken
            if (last) begin
                r.mend = 1'b1;
                if (phase == PH_OPTHDR)
                    r.st = (field_cnt != 2'd0) ? ST_SHORT_OPTHDR : ST_OK;
                else if (phase == PH_DATA)
                    r.st = ST_SHORT_DATA;
                else
                    r.st = ST_SHORT_HDR;
                status_count[r.st]++;
                clear_state();
            end
            event_count[r.ev]++;
            owed_results.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser,
                                   logic tlast);
            parse_result_t want;
            if (owed_results.size() == 0) begin
                $error("result with nothing owed: tdata 0x%0h tuser %0d tlast %0b",
                       tdata, tuser, tlast);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare("event_res", 32'(want.ev), 32'(tuser));
            compare("msg_type", 32'(want.mt), 32'(tdata[MT_LSB +: 8]));
            compare("transaction_id", 32'(want.tid), 32'(tdata[TID_LSB +: 24]));
            compare("option_type", 32'(want.ot), 32'(tdata[OT_LSB +: 16]));
            compare("option_length", 32'(want.ol), 32'(tdata[OL_LSB +: 16]));
            compare("data_byte", 32'(want.db), 32'(tdata[DB_LSB +: 8]));
            compare("data_index", 32'(want.di), 32'(tdata[DI_LSB +: 16]));
            compare("option_last", 32'(want.olast), 32'(tdata[OLAST_BIT]));
            compare("message_end", 32'(want.mend), 32'(tlast));
            compare("end_status", 32'(want.st), 32'(tdata[ST_LSB +: 2]));
            compare("tdata padding", 32'd0, 32'(tdata[OUT_TDATA_W-1:ST_LSB+2]));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    option_parse_tracker tracker = new();

    logic [8:0]  byte_stream[$];   // {message_last, in_byte}
    logic [7:0]  msg_buf[$];
    int unsigned n_messages = 0;
    int unsigned requests_sent = 0;
    int unsigned results_taken = 0;

    dhcpv6_option_stream_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

    // Move the buffered message to the stream, flagging its final byte.
    function automatic void flush_message();
        foreach (msg_buf[i])
            byte_stream.push_back({i == msg_buf.size() - 1, msg_buf[i]});
        msg_buf.delete();
        n_messages++;
    endfunction

    function automatic void add_option(logic [15:0] code, logic [15:0] len,
                                       int unsigned n_data);
        msg_buf.push_back(code[15:8]);
        msg_buf.push_back(code[7:0]);
        msg_buf.push_back(len[15:8]);
        msg_buf.push_back(len[7:0]);
        repeat (n_data) msg_buf.push_back(8'($urandom));
    endfunction

    function automatic void add_random_message();
        int unsigned pick;
        int unsigned n_opts;
        int unsigned cut;
        logic [15:0] len;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // noise: random bytes, 1 to 12 of them
            repeat ($urandom_range(1, 12)) msg_buf.push_back(8'($urandom));
        end else begin
            repeat (4) msg_buf.push_back(8'($urandom));
            n_opts = $urandom_range(0, 4);
            repeat (n_opts) begin
                len = ($urandom_range(0, 12) == 0) ? 16'($urandom_range(16, 40))
                                                   : 16'($urandom_range(0, 6));
                add_option(16'($urandom), len, int'(len));
            end
            // declared length far beyond the data that follows
            if (pick == 1)
                add_option(16'($urandom), 16'($urandom_range(256, 65535)),
                           $urandom_range(0, 4));
            // cut the message anywhere
            if (pick == 2 || pick == 3) begin
                cut = $urandom_range(1, msg_buf.size());
                while (msg_buf.size() > cut) void'(msg_buf.pop_back());
            end
        end
        flush_message();
    endfunction

    task automatic send_request(input logic [7:0] b, input logic last,
                                input int unsigned gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(b, last);
        requests_sent++;
        @(negedge aclk);
    endtask

    initial begin : drain
        int unsigned gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = ((results_taken / 100) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            // hold off long enough for the block to back up into its input
            if (results_taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_result(m_tdata, m_tuser, m_tlast);
            results_taken++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int unsigned gap;
        int unsigned directed_len;

        // short header
        msg_buf = '{8'h00};
        flush_message();
        // empty option with all-ones type, then a one-byte option closing the message
        msg_buf = '{8'h01, 8'hAB, 8'hCD, 8'hEF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                    8'h00, 8'h01, 8'h00, 8'h01, 8'h80};
        flush_message();
        // all-ones length, message ends inside the data
        msg_buf = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'h7F};
        flush_message();
        // message ends inside an option header
        msg_buf = '{8'h0C, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        flush_message();
        directed_len = byte_stream.size();
        while (byte_stream.size() < directed_len + RANDOM_BYTES)
            add_random_message();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (byte_stream[i]) begin
            gap = ((requests_sent / 90) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            send_request(byte_stream[i][7:0], byte_stream[i][8], gap);
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Streamed %0d messages, %0d bytes: %0d headers, %0d options (%0d empty)",
                 n_messages, tracker.n_bytes, tracker.event_count[EV_HDR_DONE],
                 tracker.event_count[EV_OPT_START], tracker.empty_opts);
        $display("%0d data bytes; ends ok %0d, short hdr %0d, short opt hdr %0d, short data %0d",
                 tracker.event_count[EV_OPT_DATA], tracker.status_count[ST_OK],
                 tracker.status_count[ST_SHORT_HDR], tracker.status_count[ST_SHORT_OPTHDR],
                 tracker.status_count[ST_SHORT_DATA]);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
